/* rtl/c2s_pkg.sv */
package c2s_pkg;

	// Coordinates are scaled up to fill this many bits before the square
	// root and CORDIC chains, so everything past the front end is fixed width.
	localparam int SCALED_W = 32;

	localparam int SQ_RAD_W  = 64;
	localparam int SQ_ROOT_W = 32;
	localparam int SQ_REM_W  = SQ_ROOT_W + 2;

	localparam int ROT_W         = 34;
	localparam int ACC_W         = 28;
	localparam int ANG_FRAC_DROP = 11;
	localparam int ANG_W         = ACC_W - ANG_FRAC_DROP;

	localparam int AZ_W    = 16;
	localparam int EL_W    = 15;
	localparam int RANGE_W = 20;

	localparam logic signed [ACC_W-1:0] ANG_PI_2  = 28'sd26353589;
	localparam logic signed [ACC_W-1:0] ANG_ROUND = 28'sd1024;
	localparam logic signed [ANG_W-1:0] AZ_LIMIT  = 17'sd25736;
	localparam logic signed [ANG_W-1:0] EL_LIMIT  = 17'sd12868;
	localparam logic [RANGE_W-1:0]      RANGE_MAX = '1;

	localparam int ATAN_N = 24;

	// atan(2^-i), Q24 radians
	localparam logic signed [ACC_W-1:0] ATAN_TAB [ATAN_N] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
		28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
		28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
		28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
		28'sd256,      28'sd128,     28'sd64,      28'sd32,
		28'sd16,       28'sd8,       28'sd4,       28'sd2
	};

	typedef struct packed {
		logic [SQ_RAD_W-1:0]  rad;
		logic [SQ_REM_W-1:0]  rem;
		logic [SQ_ROOT_W-1:0] root;
	} sq_digit_t;

	typedef struct packed {
		sq_digit_t                  planar;
		sq_digit_t                  full;
		logic signed [SCALED_W-1:0] xs;
		logic signed [SCALED_W-1:0] ys;
		logic signed [SCALED_W-1:0] zs;
	} sq_lane_t;

	typedef struct packed {
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
		logic signed [ACC_W-1:0] acc;
		logic                    zero;
	} rot_t;

	typedef struct packed {
		rot_t               az;
		rot_t               el;
		logic [RANGE_W-1:0] rng;
	} cd_lane_t;

endpackage

/* rtl/c2s_sqrt_cell.sv */
module c2s_sqrt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_vld,
	input  c2s_pkg::sq_lane_t in_lane,
	output logic              out_vld,
	output c2s_pkg::sq_lane_t out_lane
);

	logic              vld_s1;
	c2s_pkg::sq_lane_t lane_s1;

	// One restoring root digit: bring down two radicand bits, try 4*root+1.
	function automatic c2s_pkg::sq_digit_t digit_step(input c2s_pkg::sq_digit_t d);
		logic [c2s_pkg::SQ_REM_W-1:0] r2;
		logic [c2s_pkg::SQ_REM_W-1:0] trial;
		c2s_pkg::sq_digit_t           n;
		r2    = {d.rem[c2s_pkg::SQ_REM_W-3:0], d.rad[c2s_pkg::SQ_RAD_W-1 -: 2]};
		trial = {d.root, 2'b01};
		n.rad = d.rad << 2;
		if (r2 >= trial) begin
			n.rem  = r2 - trial;
			n.root = {d.root[c2s_pkg::SQ_ROOT_W-2:0], 1'b1};
		end else begin
			n.rem  = r2;
			n.root = {d.root[c2s_pkg::SQ_ROOT_W-2:0], 1'b0};
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s1.planar <= digit_step(in_lane.planar);
			lane_s1.full   <= digit_step(in_lane.full);
			lane_s1.xs     <= in_lane.xs;
			lane_s1.ys     <= in_lane.ys;
			lane_s1.zs     <= in_lane.zs;
		end
	end

	assign out_vld  = vld_s1;
	assign out_lane = lane_s1;

endmodule

/* rtl/c2s_cordic_cell.sv */
module c2s_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_vld,
	input  c2s_pkg::cd_lane_t in_lane,
	output logic              out_vld,
	output c2s_pkg::cd_lane_t out_lane
);

	localparam logic signed [c2s_pkg::ACC_W-1:0] ATAN_K = c2s_pkg::ATAN_TAB[STAGE];

	logic              vld_s1;
	c2s_pkg::cd_lane_t lane_s1;

	// Rotate toward the positive x axis: clockwise while y is non-negative.
	function automatic c2s_pkg::rot_t rot_step(input c2s_pkg::rot_t r);
		logic signed [c2s_pkg::ROT_W-1:0] dx;
		logic signed [c2s_pkg::ROT_W-1:0] dy;
		c2s_pkg::rot_t                    n;
		dx     = $signed(r.y) >>> STAGE;
		dy     = $signed(r.x) >>> STAGE;
		n.zero = r.zero;
		if (!r.y[c2s_pkg::ROT_W-1]) begin
			n.x   = r.x + dx;
			n.y   = r.y - dy;
			n.acc = r.acc + ATAN_K;
		end else begin
			n.x   = r.x - dx;
			n.y   = r.y + dy;
			n.acc = r.acc - ATAN_K;
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s1.az  <= rot_step(in_lane.az);
			lane_s1.el  <= rot_step(in_lane.el);
			lane_s1.rng <= in_lane.rng;
		end
	end

	assign out_vld  = vld_s1;
	assign out_lane = lane_s1;

endmodule

/* rtl/cartesian_to_spherical.sv */
// Converts one lidar point (x_mm, y_mm, z_mm) per clock, while in_ready is
// high, into azimuth and elevation in Q13 radians and the rounded Euclidean
// range in millimetres. A new word is accepted every cycle that in_ready is
// high and passes three front-end stages (magnitude, squares, sums), a chain
// of 32 square-root cells giving one root bit each, one pre-rotation and
// range-rounding stage, CORDIC_STAGES CORDIC cells that resolve both angles
// side by side, and the output register. A two-word output register pair lets
// one more result finish while a result waits; in_ready drops only when both
// are full, and then the whole chain holds until out_ready frees a slot.
module cartesian_to_spherical #(
	parameter int CORDIC_STAGES = 16,
	parameter int COORD_WIDTH   = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_WIDTH-1:0]       x_mm,
	input  logic signed [COORD_WIDTH-1:0]       y_mm,
	input  logic signed [COORD_WIDTH-1:0]       z_mm,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [c2s_pkg::AZ_W-1:0]     azimuth,
	output logic signed [c2s_pkg::EL_W-1:0]     elevation,
	output logic        [c2s_pkg::RANGE_W-1:0]  range_mm
);

	localparam int CW         = COORD_WIDTH;
	localparam int SW         = c2s_pkg::SCALED_W;
	localparam int FRAC_SHIFT = SW - CW;
	localparam int SQ_W       = 2 * CW;
	localparam int RAD_W      = c2s_pkg::SQ_RAD_W;
	localparam int ROOT_N     = c2s_pkg::SQ_ROOT_W;
	localparam int RW         = c2s_pkg::ROT_W;
	localparam int RS_W       = c2s_pkg::SQ_ROOT_W + 1;
	localparam int RMW        = c2s_pkg::SQ_REM_W;
	localparam int AW         = c2s_pkg::ANG_W;

	function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
		return v[CW-1] ? CW'(-v) : CW'(v);
	endfunction

	// Fold the left half plane onto the right with a quarter turn.
	function automatic c2s_pkg::rot_t pre_rot(input logic signed [RW-1:0] x,
		input logic signed [RW-1:0] y);
		c2s_pkg::rot_t r;
		r.zero = (x == '0) && (y == '0);
		if (x[RW-1] && !y[RW-1]) begin
			r.x   = y;
			r.y   = -x;
			r.acc = c2s_pkg::ANG_PI_2;
		end else if (x[RW-1]) begin
			r.x   = -y;
			r.y   = x;
			r.acc = -c2s_pkg::ANG_PI_2;
		end else begin
			r.x   = x;
			r.y   = y;
			r.acc = '0;
		end
		return r;
	endfunction

	function automatic logic signed [AW-1:0] angle_out(input c2s_pkg::rot_t r,
		input logic signed [AW-1:0] lim);
		logic signed [c2s_pkg::ACC_W-1:0] sum;
		logic signed [AW-1:0]             a;
		sum = r.acc + c2s_pkg::ANG_ROUND;
		a   = sum[c2s_pkg::ACC_W-1:c2s_pkg::ANG_FRAC_DROP];
		if (r.zero) begin
			a = '0;
		end else if (a > lim) begin
			a = lim;
		end else if (a < -lim) begin
			a = -lim;
		end
		return a;
	endfunction

	logic adv;

	// front end
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic [CW-1:0]        ax_s1, ay_s1, az_s1;
	logic signed [SW-1:0] xs_s1, ys_s1, zs_s1;
	logic [SQ_W-1:0]      sqx_s2, sqy_s2, sqz_s2;
	logic signed [SW-1:0] xs_s2, ys_s2, zs_s2;
	logic [SQ_W-1:0]      planar_s3, full_s3;
	logic signed [SW-1:0] xs_s3, ys_s3, zs_s3;

	// chains
	c2s_pkg::sq_lane_t sq_lane [ROOT_N+1];
	logic              sq_vld  [ROOT_N+1];
	c2s_pkg::cd_lane_t cd_lane [CORDIC_STAGES+1];
	logic              cd_vld  [CORDIC_STAGES+1];
	c2s_pkg::sq_lane_t sq_last;
	c2s_pkg::cd_lane_t pre_d;
	c2s_pkg::cd_lane_t pre_s4;
	logic [RS_W-1:0]   rng_up;

	// output pair
	logic                                inc_v;
	logic signed [AW-1:0]                inc_az, inc_el;
	logic                                out_vld_q, skid_vld_q;
	logic signed [c2s_pkg::AZ_W-1:0]     out_az_q, skid_az_q;
	logic signed [c2s_pkg::EL_W-1:0]     out_el_q, skid_el_q;
	logic        [c2s_pkg::RANGE_W-1:0]  out_rng_q, skid_rng_q;

	assign adv      = !skid_vld_q;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_vld[ROOT_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1     <= mag(x_mm);
			ay_s1     <= mag(y_mm);
			az_s1     <= mag(z_mm);
			xs_s1     <= SW'(x_mm) <<< FRAC_SHIFT;
			ys_s1     <= SW'(y_mm) <<< FRAC_SHIFT;
			zs_s1     <= SW'(z_mm) <<< FRAC_SHIFT;
			sqx_s2    <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			sqy_s2    <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			sqz_s2    <= SQ_W'(az_s1) * SQ_W'(az_s1);
			xs_s2     <= xs_s1;
			ys_s2     <= ys_s1;
			zs_s2     <= zs_s1;
			planar_s3 <= sqx_s2 + sqy_s2;
			full_s3   <= sqx_s2 + sqy_s2 + sqz_s2;
			xs_s3     <= xs_s2;
			ys_s3     <= ys_s2;
			zs_s3     <= zs_s2;
			pre_s4    <= pre_d;
		end
	end

	// Planar radicand is scaled by 4^F so its root lands in the scale of z.
	always_comb begin
		sq_lane[0].planar.rad  = RAD_W'(planar_s3) << (2 * FRAC_SHIFT);
		sq_lane[0].planar.rem  = '0;
		sq_lane[0].planar.root = '0;
		sq_lane[0].full.rad    = RAD_W'(full_s3);
		sq_lane[0].full.rem    = '0;
		sq_lane[0].full.root   = '0;
		sq_lane[0].xs          = xs_s3;
		sq_lane[0].ys          = ys_s3;
		sq_lane[0].zs          = zs_s3;
	end
	assign sq_vld[0] = v_s3;

	for (genvar k = 0; k < ROOT_N; k++) begin : g_sqrt
		c2s_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_vld   (sq_vld[k]),
			.in_lane  (sq_lane[k]),
			.out_vld  (sq_vld[k+1]),
			.out_lane (sq_lane[k+1])
		);
	end

	// Round the range up when the remainder passes the root, then saturate.
	always_comb begin
		sq_last    = sq_lane[ROOT_N];
		rng_up     = RS_W'(sq_last.full.root) + RS_W'(sq_last.full.rem > RMW'(sq_last.full.root));
		pre_d.az   = pre_rot(RW'($signed(sq_last.xs)), RW'($signed(sq_last.ys)));
		pre_d.el   = pre_rot(RW'(sq_last.planar.root), RW'($signed(sq_last.zs)));
		pre_d.rng  = (rng_up > RS_W'(c2s_pkg::RANGE_MAX)) ? c2s_pkg::RANGE_MAX
			: rng_up[c2s_pkg::RANGE_W-1:0];
	end

	assign cd_lane[0] = pre_s4;
	assign cd_vld[0]  = v_s4;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		c2s_cordic_cell #(
			.STAGE (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_vld   (cd_vld[k]),
			.in_lane  (cd_lane[k]),
			.out_vld  (cd_vld[k+1]),
			.out_lane (cd_lane[k+1])
		);
	end

	assign inc_v  = cd_vld[CORDIC_STAGES] && !skid_vld_q;
	assign inc_az = angle_out(cd_lane[CORDIC_STAGES].az, c2s_pkg::AZ_LIMIT);
	assign inc_el = angle_out(cd_lane[CORDIC_STAGES].el, c2s_pkg::EL_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= inc_v;
			end
		end else if (inc_v) begin
			skid_vld_q <= 1'b1;
		end
	end

	// Refill the output word when free, else park the new word in the skid slot.
	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_az_q  <= skid_az_q;
				out_el_q  <= skid_el_q;
				out_rng_q <= skid_rng_q;
			end else begin
				out_az_q  <= inc_az[c2s_pkg::AZ_W-1:0];
				out_el_q  <= inc_el[c2s_pkg::EL_W-1:0];
				out_rng_q <= cd_lane[CORDIC_STAGES].rng;
			end
		end else if (inc_v) begin
			skid_az_q  <= inc_az[c2s_pkg::AZ_W-1:0];
			skid_el_q  <= inc_el[c2s_pkg::EL_W-1:0];
			skid_rng_q <= cd_lane[CORDIC_STAGES].rng;
		end
	end

	assign out_valid = out_vld_q;
	assign azimuth   = out_az_q;
	assign elevation = out_el_q;
	assign range_mm  = out_rng_q;

endmodule

/* rtl/c2s_checker.sv */
module c2s_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [c2s_pkg::AZ_W-1:0]    azimuth,
	input logic signed [c2s_pkg::EL_W-1:0]    elevation,
	input logic        [c2s_pkg::RANGE_W-1:0] range_mm
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(azimuth)
			&& $stable(elevation) && $stable(range_mm))
		else $error("output word changed while stalled");

	a_angle_limits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> azimuth <= c2s_pkg::AZ_LIMIT && azimuth >= -c2s_pkg::AZ_LIMIT
			&& elevation <= c2s_pkg::EL_LIMIT && elevation >= -c2s_pkg::EL_LIMIT)
		else $error("angle outside clamp limits");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_mm == '0 |-> azimuth == '0 && elevation == '0)
		else $error("origin point gave a nonzero angle");

	a_full_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no output word pending");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !out_ready |=> !in_ready)
		else $error("input reopened without an output word taken");

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.azimuth   (azimuth),
	.elevation (elevation),
	.range_mm  (range_mm)
);

/* tb/tb.sv */
module tb;

	localparam int CW      = 20;
	localparam int CORDIC_N = 16;
	localparam int FRAC    = 32 - CW;
	localparam int MAXC    = 2 ** (CW - 1) - 1;
	localparam int MINC    = -(2 ** (CW - 1));
	localparam int N_RANDOM = 1830;
	localparam int DRAIN   = CORDIC_N + 37 + 40;
	localparam int IDLE_LIMIT = 2000;

	localparam longint HALF_PI   = 26353589;
	localparam longint AZ_CLAMP  = 25736;
	localparam longint EL_CLAMP  = 12868;
	localparam longint RANGE_TOP = 1048575;

	// atan(2^-i) in Q24 radians
	localparam longint ARCTAN [24] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} point_t;

	typedef struct packed {
		logic signed [c2s_pkg::AZ_W-1:0]    az;
		logic signed [c2s_pkg::EL_W-1:0]    el;
		logic        [c2s_pkg::RANGE_W-1:0] rng;
	} spher_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic signed [CW-1:0]               x_mm = '0;
	logic signed [CW-1:0]               y_mm = '0;
	logic signed [CW-1:0]               z_mm = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic signed [c2s_pkg::AZ_W-1:0]    azimuth;
	logic signed [c2s_pkg::EL_W-1:0]    elevation;
	logic        [c2s_pkg::RANGE_W-1:0] range_mm;

	point_t points_q [$];
	spher_t spher_q [$];
	int     errors = 0;
	int     send_gap = 0;
	int     stall = 0;
	int     idle_cycles = 0;
	logic   calm_in = 1'b0;
	logic   calm_out = 1'b0;

	cartesian_to_spherical #(
		.CORDIC_STAGES(CORDIC_N),
		.COORD_WIDTH  (CW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.x_mm     (x_mm),
		.y_mm     (y_mm),
		.z_mm     (z_mm),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.azimuth  (azimuth),
		.elevation(elevation),
		.range_mm (range_mm)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		probe = 64'h1 << 62;
		while (probe > n)
			probe = probe >> 2;
		while (probe != 0) begin
			if (n >= root + probe) begin
				n = n - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// Vectoring CORDIC, result in Q13 radians before clamping
	function automatic longint cordic_angle(longint px, longint py);
		longint acc;
		longint t;
		longint dx;
		longint dy;
		int     i;
		acc = 0;
		if (px == 0 && py == 0)
			return 0;
		// pre-rotate the left half plane by a quarter turn
		if (px < 0) begin
			if (py >= 0) begin
				t = px; px = py; py = -t; acc = HALF_PI;
			end else begin
				t = px; px = -py; py = t; acc = -HALF_PI;
			end
		end
		for (i = 0; i < CORDIC_N; i++) begin
			dx = py >>> i;
			dy = px >>> i;
			if (py >= 0) begin
				px = px + dx; py = py - dy; acc = acc + ARCTAN[i];
			end else begin
				px = px - dx; py = py + dy; acc = acc - ARCTAN[i];
			end
		end
		return (acc + 1024) >>> 11;
	endfunction

	function automatic longint clamp_sym(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic spher_t to_spherical(point_t p);
		longint          px;
		longint          py;
		longint          pz;
		longint unsigned plane2;
		longint unsigned full2;
		longint unsigned rng;
		longint          rxy;
		longint          az;
		longint          el;
		spher_t          r;
		px = p.x;
		py = p.y;
		pz = p.z;
		plane2 = px * px + py * py;
		full2 = plane2 + pz * pz;
		rxy = longint'(int_sqrt(plane2 << (2 * FRAC)));
		rng = int_sqrt(full2);
		if (full2 - rng * rng > rng)
			rng = rng + 1;
		if (rng > RANGE_TOP)
			rng = RANGE_TOP;
		az = clamp_sym(cordic_angle(px <<< FRAC, py <<< FRAC), AZ_CLAMP);
		el = clamp_sym(cordic_angle(rxy, pz <<< FRAC), EL_CLAMP);
		r.az = az[c2s_pkg::AZ_W-1:0];
		r.el = el[c2s_pkg::EL_W-1:0];
		r.rng = rng[c2s_pkg::RANGE_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("MISMATCH %s: got %0d, want %0d", what, got, want);
	endtask

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int rand_coord();
		int v;
		case ($urandom_range(0, 7))
			0, 1, 2: begin
				v = $urandom;
				return v >>> (32 - CW);
			end
			3: begin
				case ($urandom_range(0, 4))
					0: return MAXC;
					1: return MINC;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
			4: return int'($urandom_range(0, 2000)) - 1000;
			5: begin
				v = $urandom_range(0, 1 << $urandom_range(0, CW - 2));
				return ($urandom_range(0, 1) == 1) ? -v : v;
			end
			6: return 0;
			default: begin
				v = MAXC - int'($urandom_range(0, 50));
				return ($urandom_range(0, 1) == 1) ? -v : v;
			end
		endcase
	endfunction

	task automatic add_point(int px, int py, int pz);
		point_t p;
		p.x = CW'(px);
		p.y = CW'(py);
		p.z = CW'(pz);
		points_q.insert(points_q.size(), p);
	endtask

	task automatic add_random_point();
		int px;
		int py;
		int pz;
		int shape;
		shape = $urandom_range(0, 19);
		px = rand_coord();
		py = rand_coord();
		pz = rand_coord();
		case (shape)
			0: begin
				px = 0; py = 0;
			end
			1: begin
				px = -int'($urandom_range(1, MAXC + 1)); py = 0;
			end
			2: py = ($urandom_range(0, 1) == 1 && px != MINC) ? -px : px;
			3: px = 0;
			default: ;
		endcase
		add_point(px, py, pz);
	endtask

	initial begin : stimulus
		int k;
		// origin, axes, extremes and quadrant corners
		add_point(0, 0, 0);
		add_point(1, 0, 0);
		add_point(-1, 0, 0);
		add_point(0, 1, 0);
		add_point(0, -1, 0);
		add_point(0, 0, 1);
		add_point(0, 0, -1);
		add_point(MAXC, 0, 0);
		add_point(MINC, 0, 0);
		add_point(0, MAXC, 0);
		add_point(0, MINC, 0);
		add_point(0, 0, MAXC);
		add_point(0, 0, MINC);
		add_point(MAXC, MAXC, MAXC);
		add_point(MINC, MINC, MINC);
		add_point(MAXC, MINC, 0);
		add_point(MINC, MAXC, MINC);
		add_point(MINC, -1, 0);
		add_point(-5, 0, 7);
		add_point(MINC, 0, MAXC);
		add_point(3, 4, 12);
		add_point(1, 1, 0);
		add_point(1, 1, 1);
		add_point(-1, -1, -1);
		for (k = 0; k < N_RANDOM; k++)
			add_random_point();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (points_q.size() != 0 || spher_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin : driver
		logic   v_next;
		point_t nxt;
		if (arst_n) begin
			v_next = in_valid;
			if (in_valid && in_ready) begin
				nxt.x = x_mm;
				nxt.y = y_mm;
				nxt.z = z_mm;
				spher_q.insert(spher_q.size(), to_spherical(nxt));
				void'(points_q.pop_front());
				v_next = 1'b0;
				if ($urandom_range(0, 63) == 0)
					calm_in = !calm_in;
				send_gap = calm_in ? 0 : pick_gap();
			end
			// hold valid and payload until the word is taken
			if (!v_next) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (points_q.size() != 0) begin
					v_next = 1'b1;
					nxt = points_q[0];
					x_mm <= nxt.x;
					y_mm <= nxt.y;
					z_mm <= nxt.z;
				end
			end
			in_valid <= v_next;
		end
	end

	always @(posedge clk) begin : monitor
		logic   r_next;
		spher_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (spher_q.size() == 0) begin
					report_mismatch("output word with nothing expected, range", range_mm, 0);
				end else begin
					want = spher_q.pop_front();
					if (azimuth !== want.az)
						report_mismatch("azimuth", azimuth, want.az);
					if (elevation !== want.el)
						report_mismatch("elevation", elevation, want.el);
					if (range_mm !== want.rng)
						report_mismatch("range_mm", range_mm, want.rng);
				end
			end
			if ($urandom_range(0, 255) == 0)
				calm_out = !calm_out;
			if (stall > 0) begin
				stall--;
				r_next = 1'b0;
			end else begin
				r_next = 1'b1;
				if (!calm_out && $urandom_range(0, 7) == 0)
					stall = pick_gap();
			end
			out_ready <= r_next;
		end
	end

	// End the run if no word moves on either side for too long
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

endmodule
